/* rtl/core/stl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Script token lexer package
// Shared types and constants: lexer modes, token kinds, error causes,
// character codes and the layout of one token result.
// ----------------------------------------------------------------------------
package stl_pkg;

	// Default width of the running byte position.
	localparam int POSITION_BITS_DEF = 24;

	// Fixed widths of the result fields.
	localparam int OFFSET_W = 24;
	localparam int LEN_W    = 24;
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	// Depth of the result queue; one item can push up to three results.
	localparam int FIFO_DEPTH  = 8;
	localparam int MAX_RESULTS = 3;

	// Lexer modes.
	typedef enum logic [3:0] {
		M_IDLE   = 4'd0,
		M_IDENT  = 4'd1,
		M_NUMBER = 4'd2,
		M_STRING = 4'd3,
		M_OPER   = 4'd4,
		M_HASH   = 4'd5,
		M_SLASH  = 4'd6,
		M_LINE   = 4'd7,
		M_BLOCK  = 4'd8,
		M_SKIP   = 4'd9
	} lex_mode_t;

	// Token kinds.
	localparam logic [3:0] KIND_IDENT   = 4'd0;
	localparam logic [3:0] KIND_NUMBER  = 4'd1;
	localparam logic [3:0] KIND_STRING  = 4'd2;
	localparam logic [3:0] KIND_BRACKET = 4'd3;
	localparam logic [3:0] KIND_SEP     = 4'd4;
	localparam logic [3:0] KIND_OPER    = 4'd5;
	localparam logic [3:0] KIND_HASH    = 4'd6;
	localparam logic [3:0] KIND_END     = 4'd7;
	localparam logic [3:0] KIND_ERROR   = 4'd8;

	// Error causes.
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_UNTERM  = 2'd1;
	localparam logic [1:0] CAUSE_UNKNOWN = 2'd2;

	// Character codes with a special role.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	// One token result.
	typedef struct packed {
		logic [3:0]          kind;
		logic [OFFSET_W-1:0] start;
		logic [LEN_W-1:0]    len;
		logic [1:0]          cause;
		logic                last;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/stl_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Script token lexer step
// Combinational mode update for one source byte. Produces the next lexer
// state and up to three token results in stream order.
// ----------------------------------------------------------------------------
module stl_step #(
	parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF
) (
	input  logic                      [7:0] byte_in,
	input  logic                            final_byte,
	input  stl_pkg::lex_mode_t              mode,
	input  logic                            star,
	input  logic        [POSITION_BITS-1:0] bpos,
	input  logic        [POSITION_BITS-1:0] tstart,
	input  logic       [stl_pkg::LEN_W-1:0] tlen,
	output stl_pkg::lex_mode_t              mode_n,
	output logic                            star_n,
	output logic        [POSITION_BITS-1:0] bpos_n,
	output logic        [POSITION_BITS-1:0] tstart_n,
	output logic       [stl_pkg::LEN_W-1:0] tlen_n,
	output stl_pkg::result_t                res [stl_pkg::MAX_RESULTS],
	output logic                      [1:0] res_cnt
);

	localparam int OW = stl_pkg::OFFSET_W;
	localparam int LW = stl_pkg::LEN_W;

	// Character classes.
	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			c == stl_pkg::CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == stl_pkg::CH_LF;
	endfunction

	function automatic logic is_bracket(input logic [7:0] c);
		return c == 8'h28 || c == 8'h29 || c == 8'h5B || c == 8'h5D ||
			c == 8'h7B || c == 8'h7D;
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return c == 8'h3B || c == 8'h2C || c == stl_pkg::CH_DOT;
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return c == 8'h2D || c == 8'h2B || c == stl_pkg::CH_STAR ||
			c == stl_pkg::CH_SLASH || c == stl_pkg::CH_DOT || c == 8'h3D ||
			c == 8'h21 || c == 8'h26 || c == 8'h7C || c == 8'h5E ||
			c == 8'h3C || c == 8'h3E || c == 8'h3A;
	endfunction

	// Builds one result from a position-wide start offset.
	function automatic stl_pkg::result_t mk(input logic [3:0] k,
		input logic [POSITION_BITS-1:0] s, input logic [LW-1:0] l,
		input logic [1:0] c, input logic lst);
		stl_pkg::result_t r;
		r.kind  = k;
		r.start = OW'(s);
		r.len   = l;
		r.cause = c;
		r.last  = lst;
		return r;
	endfunction

	stl_pkg::result_t cand [4];
	logic       [3:0] cand_v;
	logic             fresh;
	logic    [LW-1:0] tlen_inc;
	logic [POSITION_BITS-1:0] pos_inc;

	assign tlen_inc = (tlen != stl_pkg::LEN_MAX) ? tlen + LW'(1) : tlen;
	assign pos_inc  = bpos + POSITION_BITS'(1);

	// Mode update: closing of the open token, a fresh start, and end of text.
	always_comb begin
		mode_n   = mode;
		star_n   = star;
		bpos_n   = bpos;
		tstart_n = tstart;
		tlen_n   = tlen;
		fresh    = 1'b0;
		cand_v   = '0;
		for (int k = 0; k < 4; k++) begin
			cand[k] = '0;
		end

		if (mode == stl_pkg::M_SKIP) begin
			// Bytes after an unknown character are dropped up to the last one.
			if (final_byte) begin
				mode_n   = stl_pkg::M_IDLE;
				star_n   = 1'b0;
				bpos_n   = '0;
				tstart_n = '0;
				tlen_n   = '0;
			end
		end else begin
			unique case (mode)
				stl_pkg::M_IDENT: begin
					if (is_letter(byte_in) || is_digit(byte_in)) begin
						tlen_n = tlen_inc;
					end else begin
						cand[0] = mk(stl_pkg::KIND_IDENT, tstart, tlen, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[0] = 1'b1;
						fresh = 1'b1;
					end
				end
				stl_pkg::M_NUMBER: begin
					if (is_digit(byte_in) || byte_in == stl_pkg::CH_DOT) begin
						tlen_n = tlen_inc;
					end else begin
						cand[0] = mk(stl_pkg::KIND_NUMBER, tstart, tlen, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[0] = 1'b1;
						fresh = 1'b1;
					end
				end
				stl_pkg::M_OPER: begin
					if (is_sign(byte_in)) begin
						tlen_n = tlen_inc;
					end else begin
						cand[0] = mk(stl_pkg::KIND_OPER, tstart, tlen, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[0] = 1'b1;
						fresh = 1'b1;
					end
				end
				stl_pkg::M_HASH: begin
					if (is_letter(byte_in)) begin
						tlen_n = tlen_inc;
					end else begin
						cand[0] = mk(stl_pkg::KIND_HASH, tstart, tlen, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[0] = 1'b1;
						fresh = 1'b1;
					end
				end
				stl_pkg::M_STRING: begin
					tlen_n = tlen_inc;
					if (byte_in == stl_pkg::CH_QUOTE) begin
						cand[0] = mk(stl_pkg::KIND_STRING, tstart, tlen_inc,
							stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[0] = 1'b1;
						mode_n = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_SLASH: begin
					if (byte_in == stl_pkg::CH_SLASH) begin
						mode_n = stl_pkg::M_LINE;
					end else if (byte_in == stl_pkg::CH_STAR) begin
						mode_n = stl_pkg::M_BLOCK;
						star_n = 1'b0;
					end else begin
						cand[0] = mk(stl_pkg::KIND_OPER, tstart, LW'(1), stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[0] = 1'b1;
						fresh = 1'b1;
					end
				end
				stl_pkg::M_LINE: begin
					if (byte_in == stl_pkg::CH_LF) begin
						mode_n = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_BLOCK: begin
					// The closing slash counts only after a star seen inside the comment.
					if (star && byte_in == stl_pkg::CH_SLASH) begin
						mode_n = stl_pkg::M_IDLE;
						star_n = 1'b0;
					end else begin
						star_n = (byte_in == stl_pkg::CH_STAR);
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase

			// Classify a byte that starts something new.
			if (fresh) begin
				mode_n = stl_pkg::M_IDLE;
				priority if (is_space(byte_in)) begin
					mode_n = stl_pkg::M_IDLE;
				end else if (is_letter(byte_in)) begin
					mode_n = stl_pkg::M_IDENT;
					tstart_n = bpos;
					tlen_n = LW'(1);
				end else if (is_digit(byte_in)) begin
					mode_n = stl_pkg::M_NUMBER;
					tstart_n = bpos;
					tlen_n = LW'(1);
				end else if (byte_in == stl_pkg::CH_QUOTE) begin
					mode_n = stl_pkg::M_STRING;
					tstart_n = bpos;
					tlen_n = LW'(1);
				end else if (is_bracket(byte_in)) begin
					cand[1] = mk(stl_pkg::KIND_BRACKET, bpos, LW'(1), stl_pkg::CAUSE_NONE, 1'b0);
					cand_v[1] = 1'b1;
				end else if (is_sep(byte_in)) begin
					cand[1] = mk(stl_pkg::KIND_SEP, bpos, LW'(1), stl_pkg::CAUSE_NONE, 1'b0);
					cand_v[1] = 1'b1;
				end else if (byte_in == stl_pkg::CH_SLASH) begin
					mode_n = stl_pkg::M_SLASH;
					tstart_n = bpos;
					tlen_n = LW'(1);
				end else if (is_sign(byte_in)) begin
					mode_n = stl_pkg::M_OPER;
					tstart_n = bpos;
					tlen_n = LW'(1);
				end else if (byte_in == stl_pkg::CH_HASH) begin
					mode_n = stl_pkg::M_HASH;
					tstart_n = bpos;
					tlen_n = LW'(1);
				end else begin
					cand[1] = mk(stl_pkg::KIND_ERROR, bpos, LW'(1), stl_pkg::CAUSE_UNKNOWN, 1'b1);
					cand_v[1] = 1'b1;
					mode_n = stl_pkg::M_SKIP;
				end
			end

			// Advance the position, or close the text on its last byte.
			if (!final_byte) begin
				bpos_n = pos_inc;
			end else begin
				unique case (mode_n)
					stl_pkg::M_SKIP: begin
					end
					stl_pkg::M_STRING: begin
						cand[2] = mk(stl_pkg::KIND_ERROR, tstart_n, tlen_n,
							stl_pkg::CAUSE_UNTERM, 1'b1);
						cand_v[2] = 1'b1;
					end
					stl_pkg::M_IDENT: begin
						cand[2] = mk(stl_pkg::KIND_IDENT, tstart_n, tlen_n, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[2] = 1'b1;
					end
					stl_pkg::M_NUMBER: begin
						cand[2] = mk(stl_pkg::KIND_NUMBER, tstart_n, tlen_n, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[2] = 1'b1;
					end
					stl_pkg::M_OPER: begin
						cand[2] = mk(stl_pkg::KIND_OPER, tstart_n, tlen_n, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[2] = 1'b1;
					end
					stl_pkg::M_HASH: begin
						cand[2] = mk(stl_pkg::KIND_HASH, tstart_n, tlen_n, stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[2] = 1'b1;
					end
					stl_pkg::M_SLASH: begin
						cand[2] = mk(stl_pkg::KIND_OPER, tstart_n, LW'(1), stl_pkg::CAUSE_NONE, 1'b0);
						cand_v[2] = 1'b1;
					end
					default: begin
					end
				endcase
				if (mode_n != stl_pkg::M_SKIP && mode_n != stl_pkg::M_STRING) begin
					cand[3] = mk(stl_pkg::KIND_END, pos_inc, '0, stl_pkg::CAUSE_NONE, 1'b1);
					cand_v[3] = 1'b1;
				end
				mode_n   = stl_pkg::M_IDLE;
				star_n   = 1'b0;
				bpos_n   = '0;
				tstart_n = '0;
				tlen_n   = '0;
			end
		end
	end

	// Pack the valid results to the front, keeping their order.
	always_comb begin
		res_cnt = '0;
		for (int k = 0; k < stl_pkg::MAX_RESULTS; k++) begin
			res[k] = '0;
		end
		for (int k = 0; k < 4; k++) begin
			if (cand_v[k]) begin
				res[res_cnt] = cand[k];
				res_cnt = res_cnt + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/stl_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Script token lexer result queue
// Small queue of token results: up to three pushed per cycle, one popped
// per output request.
// ----------------------------------------------------------------------------
module stl_fifo #(
	parameter int DEPTH = stl_pkg::FIFO_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic               [1:0] push_cnt,
	input  stl_pkg::result_t         push_data [stl_pkg::MAX_RESULTS],
	input  logic                     pop,
	output stl_pkg::result_t         head,
	output logic                     not_empty,
	output logic [$clog2(DEPTH):0]   count
);

	localparam int PW = $clog2(DEPTH);

	stl_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	// Storage for pushed results.
	always_ff @(posedge clk) begin
		for (int k = 0; k < stl_pkg::MAX_RESULTS; k++) begin
			if (2'(k) < push_cnt) begin
				mem_q[wr_ptr_q + PW'(k)] <= push_data[k];
			end
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + (PW + 1)'(push_cnt) - (PW + 1)'(pop);
		end
	end

endmodule
`default_nettype wire

/* rtl/core/script_token_lexer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Script token lexer unit
// Streaming lexer for a C-like script: one source byte per request in,
// one token result per request out.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid/byte_stall) takes one source byte per
//   request, with final_byte set on the last byte of a text. The token
//   channel (tok_valid/tok_stall) returns kind, start offset, length,
//   error cause and a last flag for each token, then an end result (or an
//   error result that closes the stream). A new text then starts at
//   offset zero.
//   A byte is taken every cycle unless byte_stall is set. Its results
//   pass through the input register and the queue to the token channel.
//   A token is usually reported when the byte after it arrives. One byte
//   may cause up to three results; they leave through the token port at
//   one result per cycle from an eight-entry queue, and the byte channel
//   stalls while a byte is held and more than five results are queued.
//   When the receiver stalls, the head result holds and the queue fills.
//   Reset clears the lexer to idle at offset zero and empties the queue.
// ----------------------------------------------------------------------------
module script_token_lexer_unit #(
	parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic  [7:0] byte_in,
	input  logic        final_byte,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic  [3:0] kind,
	output logic [23:0] start_offset,
	output logic [23:0] length,
	output logic  [1:0] error_cause,
	output logic        last_result
);

	localparam int DEPTH = stl_pkg::FIFO_DEPTH;
	localparam int CW    = $clog2(DEPTH) + 1;
	localparam int LW    = stl_pkg::LEN_W;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// Lexer state.
	stl_pkg::lex_mode_t       mode_q;
	logic                     star_q;
	logic [POSITION_BITS-1:0] bpos_q;
	logic [POSITION_BITS-1:0] tstart_q;
	logic [LW-1:0]            tlen_q;

	stl_pkg::lex_mode_t       mode_n;
	logic                     star_n;
	logic [POSITION_BITS-1:0] bpos_n;
	logic [POSITION_BITS-1:0] tstart_n;
	logic [LW-1:0]            tlen_n;

	stl_pkg::result_t res [stl_pkg::MAX_RESULTS];
	logic [1:0]       res_cnt;
	stl_pkg::result_t head;
	logic [CW-1:0]    fifo_count;
	logic             room;
	logic             advance;
	logic             accept;

	// The queue must have room for a full burst of results before a byte is processed.
	assign room       = (fifo_count <= CW'(DEPTH - stl_pkg::MAX_RESULTS));
	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= byte_in;
			final_s1 <= final_byte;
		end
	end

	stl_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.byte_in   (byte_s1),
		.final_byte(final_s1),
		.mode      (mode_q),
		.star      (star_q),
		.bpos      (bpos_q),
		.tstart    (tstart_q),
		.tlen      (tlen_q),
		.mode_n    (mode_n),
		.star_n    (star_n),
		.bpos_n    (bpos_n),
		.tstart_n  (tstart_n),
		.tlen_n    (tlen_n),
		.res       (res),
		.res_cnt   (res_cnt)
	);

	// Lexer state update, once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= stl_pkg::M_IDLE;
			star_q   <= 1'b0;
			bpos_q   <= '0;
			tstart_q <= '0;
			tlen_q   <= '0;
		end else if (advance) begin
			mode_q   <= mode_n;
			star_q   <= star_n;
			bpos_q   <= bpos_n;
			tstart_q <= tstart_n;
			tlen_q   <= tlen_n;
		end
	end

	stl_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (advance ? res_cnt : 2'd0),
		.push_data(res),
		.pop      (tok_valid && !tok_stall),
		.head     (head),
		.not_empty(tok_valid),
		.count    (fifo_count)
	);

	// Output fields come straight from the queue head.
	assign kind         = head.kind;
	assign start_offset = head.start;
	assign length       = head.len;
	assign error_cause  = head.cause;
	assign last_result  = head.last;

endmodule
`default_nettype wire

/* rtl/core/stl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Script token lexer checker
// Port-level checks on the token channel, bound to the top level.
// ----------------------------------------------------------------------------
module stl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tok_valid,
	input logic        tok_stall,
	input logic  [3:0] kind,
	input logic [23:0] start_offset,
	input logic [23:0] length,
	input logic  [1:0] error_cause,
	input logic        last_result
);

	// A stalled result stays put.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(kind) &&
		$stable(start_offset) && $stable(length) && $stable(last_result))
		else $error("token result changed while stalled");

	// An end result has zero length, no cause, and closes the stream.
	a_end_form: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && kind == stl_pkg::KIND_END |->
		length == '0 && error_cause == stl_pkg::CAUSE_NONE && last_result)
		else $error("malformed end result");

	// A cause is reported only on an error result, which closes the stream.
	a_cause_error: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && error_cause != stl_pkg::CAUSE_NONE |->
		kind == stl_pkg::KIND_ERROR && last_result)
		else $error("error cause on a non-error result");

	// Ordinary tokens never close the stream.
	a_token_open: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && kind != stl_pkg::KIND_END && kind != stl_pkg::KIND_ERROR |->
		!last_result && error_cause == stl_pkg::CAUSE_NONE)
		else $error("token marked as last result");

endmodule

bind script_token_lexer_unit stl_checker u_stl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tok_valid   (tok_valid),
	.tok_stall   (tok_stall),
	.kind        (kind),
	.start_offset(start_offset),
	.length      (length),
	.error_cause (error_cause),
	.last_result (last_result)
);
`default_nettype wire
